>>> sv/brl_pkg.sv
// ----------------------------------------------------------------------------
// brl_pkg
// Shared types for the line rasterizer: the item kind carried by each beat.
// ----------------------------------------------------------------------------
package brl_pkg;

    typedef enum logic {
        KIND_START   = 1'b0,
        KIND_ADVANCE = 1'b1
    } t_kind;

endpackage

>>> sv/brl_engine.sv
// ----------------------------------------------------------------------------
// brl_engine
// Line state and per-beat step logic. A start beat sets up a new line and
// emits its first pixel; an advance beat emits the next pixel of a line in progress.
// ----------------------------------------------------------------------------
module brl_engine #(
    parameter int COORD_BITS = 10
) (
    input  logic                  i_clk,
    input  logic                  i_rst_n,
    input  logic                  i_fire,
    input  brl_pkg::t_kind        i_kind,
    input  logic [COORD_BITS-1:0] i_start_x,
    input  logic [COORD_BITS-1:0] i_start_y,
    input  logic [COORD_BITS-1:0] i_end_x,
    input  logic [COORD_BITS-1:0] i_end_y,
    input  logic [15:0]           i_color,
    output logic                  o_emit,
    output logic [COORD_BITS-1:0] o_pixel_x,
    output logic [COORD_BITS-1:0] o_pixel_y,
    output logic [15:0]           o_pixel_color,
    output logic                  o_last
);
    import brl_pkg::*;

    localparam int CW = COORD_BITS;
    localparam int EW = COORD_BITS + 2;

    logic          r_active;
    logic          r_steep;
    logic [CW-1:0] r_major_pos;
    logic [CW-1:0] r_major_end;
    logic [CW-1:0] r_minor_pos;
    logic [CW-1:0] r_delta_major;
    logic [CW-1:0] r_delta_minor;
    logic [CW:0]   r_error;
    logic          r_minor_down;
    logic [15:0]   r_pen_color;

    logic          n_active;
    logic [CW-1:0] n_major_pos;
    logic [CW-1:0] n_minor_pos;
    logic [CW:0]   n_error;

    logic          is_start;
    logic [CW-1:0] adx, ady;
    logic          s_steep;
    logic [CW-1:0] sw_ax, sw_ay, sw_bx, sw_by;
    logic [CW-1:0] s_ax, s_ay, s_bx, s_by;
    logic [CW-1:0] s_dmin;

    logic          c_steep;
    logic [CW-1:0] c_major_pos, c_major_end, c_minor_pos;
    logic [CW-1:0] c_dmaj, c_dmin;
    logic [CW:0]   c_error;
    logic          c_minor_down;
    logic [15:0]   c_color;

    logic [EW-1:0] err_sub, err_add;
    logic          is_last;

    always_comb begin
        is_start = (i_kind == KIND_START);

        adx = (i_start_x > i_end_x) ? i_start_x - i_end_x : i_end_x - i_start_x;
        ady = (i_start_y > i_end_y) ? i_start_y - i_end_y : i_end_y - i_start_y;
        s_steep = ady > adx;
        sw_ax = s_steep ? i_start_y : i_start_x;
        sw_ay = s_steep ? i_start_x : i_start_y;
        sw_bx = s_steep ? i_end_y   : i_end_x;
        sw_by = s_steep ? i_end_x   : i_end_y;
        if (sw_ax > sw_bx) begin
            s_ax = sw_bx;
            s_ay = sw_by;
            s_bx = sw_ax;
            s_by = sw_ay;
        end else begin
            s_ax = sw_ax;
            s_ay = sw_ay;
            s_bx = sw_bx;
            s_by = sw_by;
        end
        s_dmin = (s_ay > s_by) ? s_ay - s_by : s_by - s_ay;

        if (is_start) begin
            c_steep      = s_steep;
            c_major_pos  = s_ax;
            c_major_end  = s_bx;
            c_minor_pos  = s_ay;
            c_dmaj       = s_bx - s_ax;
            c_dmin       = s_dmin;
            c_error      = {2'b00, c_dmaj[CW-1:1]};
            c_minor_down = !(s_ay < s_by);
            c_color      = i_color;
        end else begin
            c_steep      = r_steep;
            c_major_pos  = r_major_pos;
            c_major_end  = r_major_end;
            c_minor_pos  = r_minor_pos;
            c_dmaj       = r_delta_major;
            c_dmin       = r_delta_minor;
            c_error      = r_error;
            c_minor_down = r_minor_down;
            c_color      = r_pen_color;
        end

        is_last       = (c_major_pos == c_major_end);
        o_emit        = i_fire && (is_start || r_active);
        o_pixel_x     = c_steep ? c_minor_pos : c_major_pos;
        o_pixel_y     = c_steep ? c_major_pos : c_minor_pos;
        o_pixel_color = c_color;
        o_last        = is_last;

        err_sub = {c_error[CW], c_error} - {2'b00, c_dmin};
        err_add = err_sub + {2'b00, c_dmaj};
        if (err_sub[EW-1]) begin
            n_error     = err_add[CW:0];
            n_minor_pos = c_minor_down ? c_minor_pos - 1'b1 : c_minor_pos + 1'b1;
        end else begin
            n_error     = err_sub[CW:0];
            n_minor_pos = c_minor_pos;
        end
        n_major_pos = c_major_pos + 1'b1;
        n_active    = !is_last;
    end

    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_active <= 1'b0;
        end else if (o_emit) begin
            r_active <= n_active;
        end
    end

    always_ff @(posedge i_clk) begin
        if (o_emit) begin
            r_steep       <= c_steep;
            r_major_pos   <= n_major_pos;
            r_major_end   <= c_major_end;
            r_minor_pos   <= n_minor_pos;
            r_delta_major <= c_dmaj;
            r_delta_minor <= c_dmin;
            r_error       <= n_error;
            r_minor_down  <= c_minor_down;
            r_pen_color   <= c_color;
        end
    end

endmodule

>>> sv/bresenham_line_rasterizer.sv
// ----------------------------------------------------------------------------
// bresenham_line_rasterizer
// A beat held in the input register steps the line state when it fires, and its
// pixel goes into the output register once that register can take it. Throughput:
// one beat per cycle while i_stall is low, one pixel per start beat and per
// advance beat of a line in progress. Reset is synchronous, active low; it
// empties both registers and leaves the block idle with no line in progress.
// ----------------------------------------------------------------------------
module bresenham_line_rasterizer #(
    parameter int COORD_BITS = 10
) (
    input  logic                  i_clk,
    input  logic                  i_rst_n,
    input  logic                  i_valid,
    output logic                  o_stall,
    input  logic                  i_kind,
    input  logic [COORD_BITS-1:0] i_start_x,
    input  logic [COORD_BITS-1:0] i_start_y,
    input  logic [COORD_BITS-1:0] i_end_x,
    input  logic [COORD_BITS-1:0] i_end_y,
    input  logic [15:0]           i_color,
    output logic                  o_valid,
    input  logic                  i_stall,
    output logic [COORD_BITS-1:0] o_pixel_x,
    output logic [COORD_BITS-1:0] o_pixel_y,
    output logic [15:0]           o_pixel_color,
    output logic                  o_last
);
    import brl_pkg::*;

    logic                  r_in_valid;
    t_kind                 r_in_kind;
    logic [COORD_BITS-1:0] r_in_start_x, r_in_start_y, r_in_end_x, r_in_end_y;
    logic [15:0]           r_in_color;

    logic                  r_out_valid;
    logic [COORD_BITS-1:0] r_out_x, r_out_y;
    logic [15:0]           r_out_color;
    logic                  r_out_last;

    logic                  out_ready;
    logic                  fire;
    logic                  in_accept;
    logic                  emit;
    logic [COORD_BITS-1:0] e_x, e_y;
    logic [15:0]           e_color;
    logic                  e_last;

    assign out_ready = !r_out_valid || !i_stall;
    assign fire      = r_in_valid && out_ready;
    assign o_stall   = r_in_valid && !out_ready;
    assign in_accept = i_valid && !o_stall;

    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_in_valid <= 1'b0;
        end else if (in_accept) begin
            r_in_valid <= 1'b1;
        end else if (fire) begin
            r_in_valid <= 1'b0;
        end
    end

    always_ff @(posedge i_clk) begin
        if (in_accept) begin
            r_in_kind    <= t_kind'(i_kind);
            r_in_start_x <= i_start_x;
            r_in_start_y <= i_start_y;
            r_in_end_x   <= i_end_x;
            r_in_end_y   <= i_end_y;
            r_in_color   <= i_color;
        end
    end

    brl_engine #(
        .COORD_BITS(COORD_BITS)
    ) u_engine (
        .i_clk        (i_clk),
        .i_rst_n      (i_rst_n),
        .i_fire       (fire),
        .i_kind       (r_in_kind),
        .i_start_x    (r_in_start_x),
        .i_start_y    (r_in_start_y),
        .i_end_x      (r_in_end_x),
        .i_end_y      (r_in_end_y),
        .i_color      (r_in_color),
        .o_emit       (emit),
        .o_pixel_x    (e_x),
        .o_pixel_y    (e_y),
        .o_pixel_color(e_color),
        .o_last       (e_last)
    );

    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_out_valid <= 1'b0;
        end else if (emit) begin
            r_out_valid <= 1'b1;
        end else if (!i_stall) begin
            r_out_valid <= 1'b0;
        end
    end

    always_ff @(posedge i_clk) begin
        if (emit) begin
            r_out_x     <= e_x;
            r_out_y     <= e_y;
            r_out_color <= e_color;
            r_out_last  <= e_last;
        end
    end

    assign o_valid       = r_out_valid;
    assign o_pixel_x     = r_out_x;
    assign o_pixel_y     = r_out_y;
    assign o_pixel_color = r_out_color;
    assign o_last        = r_out_last;

endmodule

>>> verif/tb.sv
`timescale 1ns / 100ps
// ----------------------------------------------------------------------------
// tb
// Self-checking bench for the line rasterizer. A driver feeds start and advance
// beats from a command queue, a line tracer predicts every pixel as each beat
// is accepted, and a monitor compares each pixel beat with the oldest
// prediction. Both sides idle and stall at random.
// ----------------------------------------------------------------------------
module tb;
    import brl_pkg::*;

    localparam int CB       = 10;
    localparam int MAX_IDLE = 2000;

    typedef struct {
        t_kind           kind;
        logic [CB-1:0]   ax;
        logic [CB-1:0]   ay;
        logic [CB-1:0]   bx;
        logic [CB-1:0]   by;
        logic [15:0]     color;
    } line_cmd_t;

    typedef struct {
        logic [CB-1:0]   x;
        logic [CB-1:0]   y;
        logic [15:0]     color;
        logic            last;
    } pixel_t;

    logic            i_clk         = 1'b0;
    logic            i_rst_n       = 1'b0;
    logic            i_valid       = 1'b0;
    logic            o_stall;
    logic            i_kind        = KIND_ADVANCE;
    logic [CB-1:0]   i_start_x     = '0;
    logic [CB-1:0]   i_start_y     = '0;
    logic [CB-1:0]   i_end_x       = '0;
    logic [CB-1:0]   i_end_y       = '0;
    logic [15:0]     i_color       = '0;
    logic            o_valid;
    logic            i_stall       = 1'b0;
    logic [CB-1:0]   o_pixel_x;
    logic [CB-1:0]   o_pixel_y;
    logic [15:0]     o_pixel_color;
    logic            o_last;

    line_cmd_t       line_cmds[$];
    pixel_t          due_pixels[$];
    line_cmd_t       cur_cmd;
    int              sent_count    = 0;
    int              total_cmds    = 0;
    int              pixel_count   = 0;
    int              mismatches    = 0;
    int              gap_left      = 0;
    int              burst_left    = 0;
    int              stall_left    = 0;
    logic            stall_hold    = 1'b0;
    logic            draining      = 1'b0;
    int              idle_cycles   = 0;

    logic            tr_active     = 1'b0;
    logic            tr_steep      = 1'b0;
    logic [CB-1:0]   tr_major      = '0;
    logic [CB-1:0]   tr_major_end  = '0;
    logic [CB-1:0]   tr_minor      = '0;
    logic [CB-1:0]   tr_dmajor     = '0;
    logic [CB-1:0]   tr_dminor     = '0;
    logic signed [CB:0] tr_err     = '0;
    logic            tr_down       = 1'b0;
    logic [15:0]     tr_color      = '0;

    bresenham_line_rasterizer #(
        .COORD_BITS(CB)
    ) i_dut (
        .i_clk         (i_clk),
        .i_rst_n       (i_rst_n),
        .i_valid       (i_valid),
        .o_stall       (o_stall),
        .i_kind        (i_kind),
        .i_start_x     (i_start_x),
        .i_start_y     (i_start_y),
        .i_end_x       (i_end_x),
        .i_end_y       (i_end_y),
        .i_color       (i_color),
        .o_valid       (o_valid),
        .i_stall       (i_stall),
        .o_pixel_x     (o_pixel_x),
        .o_pixel_y     (o_pixel_y),
        .o_pixel_color (o_pixel_color),
        .o_last        (o_last)
    );

    always #6 i_clk = ~i_clk;

    task automatic report_mismatch(input string msg);
        $display("%0t ERROR %s", $time, msg);
        mismatches++;
    endtask

    // The current pixel is predicted, then the tracer steps one position along the major axis.
    task automatic emit_pixel();
        pixel_t p;
        p.last  = (tr_major == tr_major_end);
        p.x     = tr_steep ? tr_minor : tr_major;
        p.y     = tr_steep ? tr_major : tr_minor;
        p.color = tr_color;
        due_pixels.push_back(p);
        tr_err = tr_err - $signed({1'b0, tr_dminor});
        if (tr_err < 0) begin
            tr_minor = tr_down ? tr_minor - 1'b1 : tr_minor + 1'b1;
            tr_err   = tr_err + $signed({1'b0, tr_dmajor});
        end
        tr_major = tr_major + 1'b1;
        if (p.last) begin
            tr_active = 1'b0;
        end
    endtask

    task automatic raster_step(input line_cmd_t c);
        logic [CB-1:0] ax;
        logic [CB-1:0] ay;
        logic [CB-1:0] bx;
        logic [CB-1:0] by;
        logic [CB-1:0] adx;
        logic [CB-1:0] ady;
        logic [CB-1:0] t;
        if (c.kind == KIND_START) begin
            ax = c.ax;
            ay = c.ay;
            bx = c.bx;
            by = c.by;
            adx = (ax > bx) ? ax - bx : bx - ax;
            ady = (ay > by) ? ay - by : by - ay;
            tr_steep = (ady > adx);
            if (tr_steep) begin
                t = ax; ax = ay; ay = t;
                t = bx; bx = by; by = t;
            end
            if (ax > bx) begin
                t = ax; ax = bx; bx = t;
                t = ay; ay = by; by = t;
            end
            tr_major     = ax;
            tr_major_end = bx;
            tr_minor     = ay;
            tr_dmajor    = bx - ax;
            tr_dminor    = (ay > by) ? ay - by : by - ay;
            tr_err       = $signed({1'b0, tr_dmajor >> 1});
            tr_down      = !(ay < by);
            tr_color     = c.color;
            tr_active    = 1'b1;
            emit_pixel();
        end else if (tr_active) begin
            emit_pixel();
        end
    endtask

    function automatic int pick_gap();
        int r;
        if (burst_left > 0) begin
            burst_left--;
            return 0;
        end
        r = $urandom_range(0, 99);
        if (r < 3) begin
            burst_left = $urandom_range(30, 150);
            return 0;
        end
        if (r < 55) return 0;
        if (r < 92) return $urandom_range(1, 3);
        return $urandom_range(10, 40);
    endfunction

    function automatic logic [CB-1:0] nudge(input logic [CB-1:0] base, input int spread);
        int v;
        v = int'(base) + int'($urandom_range(0, 2 * spread)) - spread;
        if (v < 0) v = 0;
        if (v > 1023) v = 1023;
        return v[CB-1:0];
    endfunction

    function automatic int line_span(input logic [CB-1:0] ax, input logic [CB-1:0] ay,
                                     input logic [CB-1:0] bx, input logic [CB-1:0] by);
        int dx;
        int dy;
        dx = (ax > bx) ? int'(ax - bx) : int'(bx - ax);
        dy = (ay > by) ? int'(ay - by) : int'(by - ay);
        return (dx > dy) ? dx : dy;
    endfunction

    task automatic push_cmd(input t_kind k, input logic [CB-1:0] ax, input logic [CB-1:0] ay,
                            input logic [CB-1:0] bx, input logic [CB-1:0] by,
                            input logic [15:0] color);
        line_cmd_t c;
        c.kind  = k;
        c.ax    = ax;
        c.ay    = ay;
        c.bx    = bx;
        c.by    = by;
        c.color = color;
        line_cmds.push_back(c);
    endtask

    task automatic push_advances(input int n);
        for (int i = 0; i < n; i++) begin
            push_cmd(KIND_ADVANCE, CB'($urandom_range(0, 1023)), CB'($urandom_range(0, 1023)),
                     CB'($urandom_range(0, 1023)), CB'($urandom_range(0, 1023)),
                     16'($urandom_range(0, 65535)));
        end
    endtask

    always @(posedge i_clk) begin
        if (!i_rst_n) begin
            i_valid <= 1'b0;
        end else begin
            if (i_valid && !o_stall) begin
                raster_step(cur_cmd);
                sent_count++;
                gap_left = pick_gap();
            end
            if (!i_valid || !o_stall) begin
                if (gap_left == 0 && line_cmds.size() != 0) begin
                    cur_cmd = line_cmds.pop_front();
                    i_kind    <= cur_cmd.kind;
                    i_start_x <= cur_cmd.ax;
                    i_start_y <= cur_cmd.ay;
                    i_end_x   <= cur_cmd.bx;
                    i_end_y   <= cur_cmd.by;
                    i_color   <= cur_cmd.color;
                    i_valid   <= 1'b1;
                end else begin
                    i_valid <= 1'b0;
                    if (gap_left != 0) gap_left--;
                end
            end
        end
    end

    always @(posedge i_clk) begin
        pixel_t want;
        int r;
        if (!i_rst_n) begin
            i_stall <= 1'b0;
        end else begin
            if (o_valid && !i_stall) begin
                if (due_pixels.size() == 0) begin
                    report_mismatch($sformatf("pixel (%0d,%0d) with none due",
                                              o_pixel_x, o_pixel_y));
                end else begin
                    want = due_pixels.pop_front();
                    if (o_pixel_x !== want.x)
                        report_mismatch($sformatf("pixel %0d x got %0d expected %0d",
                                                  pixel_count, o_pixel_x, want.x));
                    if (o_pixel_y !== want.y)
                        report_mismatch($sformatf("pixel %0d y got %0d expected %0d",
                                                  pixel_count, o_pixel_y, want.y));
                    if (o_pixel_color !== want.color)
                        report_mismatch($sformatf("pixel %0d color got %h expected %h",
                                                  pixel_count, o_pixel_color, want.color));
                    if (o_last !== want.last)
                        report_mismatch($sformatf("pixel %0d last got %b expected %b",
                                                  pixel_count, o_last, want.last));
                end
                pixel_count++;
            end
            if (stall_left == 0) begin
                r = $urandom_range(0, 99);
                if (r < 50) begin
                    stall_hold = 1'b0;
                    stall_left = $urandom_range(1, 8);
                end else if (r < 85) begin
                    stall_hold = 1'b1;
                    stall_left = $urandom_range(1, 3);
                end else if (r < 95) begin
                    stall_hold = 1'b1;
                    stall_left = $urandom_range(10, 40);
                end else begin
                    stall_hold = 1'b0;
                    stall_left = $urandom_range(40, 150);
                end
            end
            stall_left--;
            i_stall <= draining ? 1'b0 : stall_hold;
        end
    end

    always @(posedge i_clk) begin
        if (i_rst_n) begin
            if ((i_valid && !o_stall) || (o_valid && !i_stall)) begin
                idle_cycles = 0;
            end else begin
                idle_cycles++;
            end
            if (idle_cycles >= MAX_IDLE) begin
                $display("Regression FAIL");
                $finish;
            end
        end
    end

    initial begin
        int produced;
        int span;
        int n;
        int r;
        int spread;
        logic [CB-1:0] ax;
        logic [CB-1:0] ay;
        logic [CB-1:0] bx;
        logic [CB-1:0] by;

        push_cmd(KIND_ADVANCE, 10'h3FF, 10'h3FF, 10'h3FF, 10'h3FF, 16'hFFFF);
        push_cmd(KIND_START, 10'd1023, 10'd1023, 10'd1023, 10'd1023, 16'hFFFF);
        push_cmd(KIND_ADVANCE, 10'd0, 10'd0, 10'd0, 10'd0, 16'h0000);
        push_cmd(KIND_START, 10'd0, 10'd0, 10'd0, 10'd0, 16'h0000);
        push_cmd(KIND_START, 10'd10, 10'd7, 10'd14, 10'd7, 16'h1234);
        push_advances(4);
        push_cmd(KIND_START, 10'd100, 10'd200, 10'd101, 10'd196, 16'hF81F);
        push_advances(5);
        push_cmd(KIND_START, 10'd1023, 10'd0, 10'd0, 10'd1023, 16'hA5A5);
        push_advances(2);
        push_cmd(KIND_START, 10'd0, 10'd1023, 10'd1023, 10'd0, 16'h5A5A);
        push_advances(2);
        push_cmd(KIND_START, 10'd3, 10'd0, 10'd0, 10'd1023, 16'h07E0);
        push_advances(1);
        produced = 23;

        // Most lines are short and run to their end; some are cut short by the next start,
        // some get extra advances after the block has gone idle.
        while (produced < 1650) begin
            r = $urandom_range(0, 99);
            if (r < 5) begin
                push_advances(1);
                continue;
            end
            ax = CB'($urandom_range(0, 1023));
            ay = CB'($urandom_range(0, 1023));
            if (r < 90) begin
                spread = (r < 75) ? 12 : 60;
                bx = nudge(ax, spread);
                by = nudge(ay, spread);
            end else begin
                bx = CB'($urandom_range(0, 1023));
                by = CB'($urandom_range(0, 1023));
            end
            span = line_span(ax, ay, bx, by);
            r = $urandom_range(0, 99);
            if (span > 100) begin
                n = $urandom_range(0, 20);
            end else if (r < 70) begin
                n = span;
            end else if (r < 85) begin
                n = $urandom_range(0, span);
            end else begin
                n = span + $urandom_range(1, 3);
            end
            push_cmd(KIND_START, ax, ay, bx, by, 16'($urandom_range(0, 65535)));
            push_advances(n);
            produced += 1 + ((n < span) ? n : span);
        end
        total_cmds = line_cmds.size();

        repeat (5) @(posedge i_clk);
        i_rst_n <= 1'b1;

        while (!(sent_count == total_cmds && due_pixels.size() == 0)) begin
            @(posedge i_clk);
        end
        draining = 1'b1;
        repeat (12) @(posedge i_clk);
        if (mismatches == 0) begin
            $display("Regression PASS");
        end else begin
            $display("Regression FAIL");
        end
        $finish;
    end

endmodule

>>> sim.f
sv/brl_pkg.sv
sv/brl_engine.sv
sv/bresenham_line_rasterizer.sv
verif/tb.sv
